FILE: sv/voxel_box_downsample_macros.svh
// Assertion helpers for the voxel box downsampler.
// Each macro expands to one labeled concurrent assertion on clk, muted in reset.
`ifndef VOXEL_BOX_DOWNSAMPLE_MACROS_SVH
`define VOXEL_BOX_DOWNSAMPLE_MACROS_SVH

// Same-cycle implication.
`define VBD_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define VBD_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: sv/vbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbd_pkg
// Shared types and constants of the voxel box downsampler.
// ---------------------------------------------------------------------------
package vbd_pkg;

  localparam int CHUNK_BITS = 5;   // chunk edge of 32 voxels
  localparam int LEVEL_W    = 3;
  localparam int LEVEL_MAX  = 5;   // level of the largest cube that fits the chunk
  localparam int CELL_W     = 4;
  localparam int SLOT_W     = 8;
  localparam int SUM_W      = 23;
  localparam int SHIFT_W    = 4;   // holds 3 * LEVEL_MAX
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd1;

  typedef struct packed {
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [7:0] occupancy;
    logic [7:0] material_id;
  } vox_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [7:0]        mean_occupancy;
    logic [7:0]        dominant_material;
  } res_t;

  // Classified voxel handed from the front to the accumulator side.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               is_first;
    logic               is_last;
    logic [LEVEL_W-1:0] level;
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic [CELL_W-1:0]  cz;
    logic [7:0]         occupancy;
    logic [7:0]         material_id;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [7:0]       best;
    logic [7:0]       material;
  } acc_t;

  // Status of the accumulator stage, seen by the top level.
  typedef struct packed {
    logic busy;       // a voxel sits in the read-modify-write stage
    logic fire;       // that voxel retires this cycle
    logic fire_last;  // and it closes its cell
  } back_stat_t;

endpackage

FILE: sv/vbd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbd_front
// Holds the level register and classifies each accepted voxel.
// ---------------------------------------------------------------------------
module vbd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [vbd_pkg::LEVEL_W-1:0] cfg_data,
  input  logic                       vox_valid,
  input  logic                       space,
  output logic                       vox_ready,
  input  vbd_pkg::vox_t              vox,
  output vbd_pkg::push_t             q_in
);

  logic [vbd_pkg::LEVEL_W-1:0] mip_level;
  logic                        level_ok;
  logic [4:0]                  mask;
  logic [4:0]                  sx;
  logic [4:0]                  sz;
  logic [9:0]                  slot_wide;
  logic [2:0]                  zshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_level <= vbd_pkg::LEVEL_RESET;
    end else if (cfg_we) begin
      mip_level <= cfg_data;
    end
  end

  assign level_ok = (mip_level != '0) && (mip_level <= 3'(vbd_pkg::LEVEL_MAX));
  assign mask     = 5'((6'd1 << mip_level) - 6'd1);
  assign sx       = vox.pos_x >> mip_level;
  assign sz       = vox.pos_z >> mip_level;
  // Row length of the slab is 32 >> level, so the z index moves up by 5 - level bits.
  assign zshift    = 3'(3'(vbd_pkg::CHUNK_BITS) - mip_level);
  assign slot_wide = ({5'd0, sz} << zshift) | {5'd0, sx};

  assign vox_ready = space;

  always_comb begin
    q_in.push            = vox_valid && space && level_ok;
    q_in.job.slot        = slot_wide[vbd_pkg::SLOT_W-1:0];
    q_in.job.is_first    = ((vox.pos_x | vox.pos_y | vox.pos_z) & mask) == 5'd0;
    q_in.job.is_last     = ((vox.pos_x & vox.pos_y & vox.pos_z) & mask) == mask;
    q_in.job.level       = mip_level;
    q_in.job.cx          = sx[vbd_pkg::CELL_W-1:0];
    q_in.job.cy          = 4'(vox.pos_y >> mip_level);
    q_in.job.cz          = sz[vbd_pkg::CELL_W-1:0];
    q_in.job.occupancy   = vox.occupancy;
    q_in.job.material_id = vox.material_id;
  end

endmodule

FILE: sv/vbd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbd_fifo
// Short queue of classified voxels between the front and the accumulator.
// ---------------------------------------------------------------------------
module vbd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  vbd_pkg::push_t q_in,
  input  logic           pop,
  output vbd_pkg::job_t  head,
  output logic           empty,
  output logic           full
);

  vbd_pkg::job_t                  slots [vbd_pkg::FIFO_DEPTH];
  logic [vbd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [vbd_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [vbd_pkg::FIFO_CNT_W-1:0] count;
  logic                           do_pop;

  assign empty  = count == '0;
  assign full   = count == vbd_pkg::FIFO_CNT_W'(vbd_pkg::FIFO_DEPTH);
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_in.push) begin
      slots[wr_ptr] <= q_in.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_in.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (q_in.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !q_in.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/vbd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vbd_back
// Per-cell accumulator memory with one read-modify-write per voxel,
// and the result register.
// ---------------------------------------------------------------------------
module vbd_back (
  input  logic                clk,
  input  logic                rst,
  input  vbd_pkg::job_t       head,
  input  logic                empty,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output vbd_pkg::res_t       res,
  output vbd_pkg::back_stat_t stat
);

  vbd_pkg::acc_t mem [2**vbd_pkg::SLOT_W];

  logic          b_valid;
  vbd_pkg::job_t b_job;
  vbd_pkg::acc_t rd_acc;
  logic          fwd;
  vbd_pkg::acc_t fwd_acc;

  vbd_pkg::acc_t                base;
  vbd_pkg::acc_t                acc_next;
  logic [vbd_pkg::SUM_W:0]      sum_wide;
  logic [vbd_pkg::SHIFT_W-1:0]  sh;
  logic [vbd_pkg::SUM_W:0]      rounded;
  logic [vbd_pkg::SUM_W:0]      quot;
  logic [7:0]                   mean;
  logic                         fire;

  assign fire = b_valid && (!b_job.is_last || !res_valid || res_ready);
  assign pop  = !empty && (!b_valid || fire);

  always_comb begin
    if (b_job.is_first) begin
      base = '0;
    end else if (fwd) begin
      base = fwd_acc;
    end else begin
      base = rd_acc;
    end
    sum_wide     = {1'b0, base.sum} + 24'(b_job.occupancy);
    acc_next.sum = sum_wide[vbd_pkg::SUM_W] ? vbd_pkg::SUM_MAX : sum_wide[vbd_pkg::SUM_W-1:0];
    if (b_job.occupancy > base.best) begin
      acc_next.best     = b_job.occupancy;
      acc_next.material = b_job.material_id;
    end else begin
      acc_next.best     = base.best;
      acc_next.material = base.material;
    end
    sh      = 4'({1'b0, b_job.level} << 1) + 4'(b_job.level);
    rounded = {1'b0, acc_next.sum} + (24'd1 << (sh - 4'd1));
    quot    = rounded >> sh;
    mean    = (quot[vbd_pkg::SUM_W:8] != '0) ? 8'hFF : quot[7:0];
  end

  // Registered read; a write retiring at the same edge is forwarded instead.
  always_ff @(posedge clk) begin
    if (fire) begin
      mem[b_job.slot] <= acc_next;
    end
    if (pop) begin
      rd_acc  <= mem[head.slot];
      b_job   <= head;
      fwd     <= fire && (head.slot == b_job.slot);
      fwd_acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (fire) begin
        b_valid <= 1'b0;
      end
      if (fire && b_job.is_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && b_job.is_last) begin
      res.cell_x            <= b_job.cx;
      res.cell_y            <= b_job.cy;
      res.cell_z            <= b_job.cz;
      res.mean_occupancy    <= mean;
      res.dominant_material <= acc_next.material;
    end
  end

  assign stat.busy      = b_valid;
  assign stat.fire      = fire;
  assign stat.fire_last = fire && b_job.is_last;

endmodule

FILE: sv/voxel_box_downsample.sv
`timescale 1ns / 1ps
// A cell result is registered: its last voxel passes the queue and the accumulator stage first.
// Throughput: one voxel per cycle unless a held result stalls, set by the accumulator
// memory read-modify-write, with the previous write forwarded to the next read.
// Reset (rst, synchronous) clears the queue, the stage valid and result valid
// flags and sets mip_level to 1; the accumulator memory is not cleared.
// ---------------------------------------------------------------------------
// voxel_box_downsample
// Box-filter mip reduction of a voxel chunk streamed one voxel per item.
// ---------------------------------------------------------------------------
`include "voxel_box_downsample_macros.svh"

module voxel_box_downsample (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vbd_pkg::LEVEL_W-1:0] cfg_data,
  input  logic                        vox_valid,
  output logic                        vox_ready,
  input  vbd_pkg::vox_t               vox,
  output logic                        res_valid,
  input  logic                        res_ready,
  output vbd_pkg::res_t               res
);

  // The front classifies each voxel: it works out the cube's slot in the
  // current slab, whether the voxel opens or closes its cube, and the coarse
  // cell index. Voxels taken under a level outside 1..5 are dropped here.
  vbd_pkg::push_t      q_in;
  vbd_pkg::job_t       head;
  logic                q_empty;
  logic                q_full;
  logic                pop;
  vbd_pkg::back_stat_t stat;

  vbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .vox_valid (vox_valid),
    .space     (!q_full),
    .vox_ready (vox_ready),
    .vox       (vox),
    .q_in      (q_in)
  );

  // A four-entry queue lets the front keep taking voxels while the result
  // side waits on the consumer.
  vbd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .q_in  (q_in),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // The back reads the cell's accumulator when it pops a voxel, folds the
  // voxel in and writes it back when the voxel retires. A voxel that closes
  // its cube also loads the result register with the rounded mean and the
  // material of the fullest voxel.
  vbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .stat      (stat)
  );

  `VBD_ASSERT_NOW(a_no_push_when_full, q_in.push, !q_full, "voxel pushed into a full queue")
  `VBD_ASSERT_NOW(a_pop_needs_data, pop, !q_empty, "queue popped while empty")
  `VBD_ASSERT_NEXT(a_last_gives_result, stat.fire_last, res_valid, "closing voxel gave no result")
  `VBD_ASSERT_NOW(a_retire_when_busy, stat.fire, stat.busy, "accumulator retired with no voxel")

endmodule
